### design/assert_macros.svh
// Assertion macros shared by the pedal scaler RTL.
// Depends on nothing; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication: when a holds, b holds at that edge.
`define ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("implication check failed");
// Next-cycle implication: when a holds, b holds at the following edge.
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

### design/dpps_pkg.sv
// Package for the dual pedal position scaler: payload structs, request codes,
// controller/datapath command and status structs. Depends on nothing.
package dpps_pkg;

   localparam int ADC_BITS       = 12;
   localparam int POS_BITS       = 10;
   localparam int FULL_SCALE     = 1000;
   localparam int DEADBAND_RESET = 50;
   localparam int PROD_BITS      = ADC_BITS + POS_BITS;
   localparam int QUOT_BITS      = POS_BITS;
   localparam int CNT_BITS       = $clog2(QUOT_BITS);

   localparam logic [1:0] REQ_MEASURE = 2'd0;
   localparam logic [1:0] REQ_CAP_MIN = 2'd1;
   localparam logic [1:0] REQ_CAP_MAX = 2'd2;
   localparam logic [1:0] REQ_PREVIEW = 2'd3;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [ADC_BITS-1:0] sample_a;
      logic [ADC_BITS-1:0] sample_b;
   } req_item_type;

   typedef struct packed {
      logic [POS_BITS-1:0] position;
      logic [ADC_BITS-1:0] raw_average;
      logic                range_zero;
   } rsp_item_type;

   typedef struct packed {
      logic load_req;
      logic prep;
      logic mul_init;
      logic div_step;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic is_measure;
      logic span_zero;
      logic off_ge_span;
   } dp_status_type;

endpackage

### design/dual_pedal_position_scaler_core.sv
// Top level of the dual pedal position scaler: controller plus datapath.
// Uses dpps_pkg, dpps_ctrl and dpps_datapath.
//
// Two redundant pedal sensors are scaled against a two-point calibration.
// A capture-minimum request stores both samples as minimums; a capture-maximum
// request stores both as maximums and sets each span to max minus min (zero if
// negative). Capture and preview requests answer with the truncated average of
// the two raw samples. A measure request clamps each sample into its window,
// averages offsets and spans and answers floor(offset*1000/span) in per mille,
// saturated at 1000 and forced to zero below the deadband register; a zero
// span answers 0 with range_zero set. One request is in work at a time; each
// gives exactly one response. The request is latched at the accepting edge and
// a measure request then passes clamp/average, multiply, ten divider steps of a
// one-bit restoring divider and the result load; the divider steps are skipped
// when the offset reaches the span and the quotient saturates, and for capture
// and preview requests. The result waits while the previous response is not
// yet taken. A new request is accepted as soon as the previous result sits in
// the response register, even if it is not yet taken. The deadband register is
// written through the csr port, which is always ready; write it only while
// the block is idle.

module dual_pedal_position_scaler_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  dpps_pkg::req_item_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output dpps_pkg::rsp_item_type        rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dpps_pkg::POS_BITS-1:0] csr_data
);

   dpps_pkg::dp_cmd_type    cmd;
   dpps_pkg::dp_status_type status;
   logic                    csr_write;

   // the deadband register takes a write in any cycle
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // sequence each request: latch, prepare, multiply, divide, respond
   dpps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // hold calibration, compute and register the response payload
   dpps_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

### design/dpps_datapath.sv
// Datapath of the pedal scaler: calibration registers, clamp and average,
// constant multiply, restoring divider, result register. Uses dpps_pkg.
`include "assert_macros.svh"

module dpps_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  dpps_pkg::req_item_type req_data,
   input  logic                   csr_write,
   input  logic [dpps_pkg::POS_BITS-1:0] csr_data,
   input  dpps_pkg::dp_cmd_type   cmd,
   output dpps_pkg::dp_status_type status,
   output dpps_pkg::rsp_item_type rsp_data
);

   localparam int AB = dpps_pkg::ADC_BITS;
   localparam int PB = dpps_pkg::PROD_BITS;
   localparam int QB = dpps_pkg::QUOT_BITS;
   localparam int WB = dpps_pkg::POS_BITS;

   function automatic logic [AB-1:0] span_of(input logic [AB-1:0] lo,
                                             input logic [AB-1:0] hi);
      span_of = (hi > lo) ? (hi - lo) : '0;
   endfunction

   dpps_pkg::req_item_type req_ff;
   dpps_pkg::rsp_item_type rsp_ff, rsp_in;
   logic [WB-1:0] deadband_ff;
   logic [AB-1:0] min_a_ff, max_a_ff, span_a_ff;
   logic [AB-1:0] min_b_ff, max_b_ff, span_b_ff;
   logic [AB-1:0] off_ff, off_in, span_avg_ff, span_avg_in, raw_ff, raw_in;
   logic [PB-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [QB-1:0] quot_ff, quot_in;
   logic [AB-1:0] clip_a, clip_b;
   logic [AB:0]   off_sum, span_sum, raw_sum;
   logic          take_bit;
   logic [WB-1:0] pos_sat, pos_out;

   // clamp to maximum first, then to minimum
   always_comb begin
      clip_a = (req_ff.sample_a > max_a_ff) ? max_a_ff : req_ff.sample_a;
      clip_a = (clip_a < min_a_ff) ? min_a_ff : clip_a;
      clip_b = (req_ff.sample_b > max_b_ff) ? max_b_ff : req_ff.sample_b;
      clip_b = (clip_b < min_b_ff) ? min_b_ff : clip_b;
      off_sum  = {1'b0, clip_a - min_a_ff} + {1'b0, clip_b - min_b_ff};
      span_sum = {1'b0, span_a_ff} + {1'b0, span_b_ff};
      raw_sum  = {1'b0, req_ff.sample_a} + {1'b0, req_ff.sample_b};
      off_in      = off_sum[AB:1];
      span_avg_in = span_sum[AB:1];
      raw_in      = raw_sum[AB:1];
   end

   // one quotient bit per step, divisor walks right
   always_comb begin
      take_bit = (rem_ff >= dvs_ff);
      rem_in   = take_bit ? (rem_ff - dvs_ff) : rem_ff;
      dvs_in   = dvs_ff >> 1;
      quot_in  = {quot_ff[QB-2:0], take_bit};
   end

   assign status.is_measure  = (req_ff.req_type == dpps_pkg::REQ_MEASURE);
   assign status.span_zero   = (span_avg_ff == '0);
   assign status.off_ge_span = (off_ff >= span_avg_ff);

   always_comb begin
      pos_sat = status.off_ge_span ? WB'(dpps_pkg::FULL_SCALE) : quot_ff;
      pos_out = (pos_sat < deadband_ff) ? '0 : pos_sat;
      rsp_in  = '0;
      if (status.is_measure) begin
         if (status.span_zero) begin
            rsp_in.range_zero = 1'b1;
         end else begin
            rsp_in.position = pos_out;
         end
      end else begin
         rsp_in.raw_average = raw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= WB'(dpps_pkg::DEADBAND_RESET);
         min_a_ff    <= '0;
         max_a_ff    <= '1;
         span_a_ff   <= '1;
         min_b_ff    <= '0;
         max_b_ff    <= '1;
         span_b_ff   <= '1;
      end else begin
         if (csr_write) begin
            deadband_ff <= csr_data;
         end
         if (cmd.prep) begin
            case (req_ff.req_type)
               dpps_pkg::REQ_CAP_MIN: begin
                  min_a_ff <= req_ff.sample_a;
                  min_b_ff <= req_ff.sample_b;
               end
               dpps_pkg::REQ_CAP_MAX: begin
                  max_a_ff  <= req_ff.sample_a;
                  max_b_ff  <= req_ff.sample_b;
                  span_a_ff <= span_of(min_a_ff, req_ff.sample_a);
                  span_b_ff <= span_of(min_b_ff, req_ff.sample_b);
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.prep) begin
         off_ff      <= off_in;
         span_avg_ff <= span_avg_in;
         raw_ff      <= raw_in;
      end
      if (cmd.mul_init) begin
         rem_ff  <= PB'(off_ff) * PB'(dpps_pkg::FULL_SCALE);
         dvs_ff  <= PB'(span_avg_ff) << (QB - 1);
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         dvs_ff  <= dvs_in;
         quot_ff <= quot_in;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   `ASSERT_NEXT(a_pos_full_scale, clock, reset, cmd.load_rsp, rsp_ff.position <= WB'(dpps_pkg::FULL_SCALE))
   `ASSERT_NEXT(a_zero_flag_pos, clock, reset, cmd.load_rsp, !(rsp_ff.range_zero && (rsp_ff.position != '0)))

endmodule

### design/dpps_ctrl.sv
// Controller of the pedal scaler: request sequencing, divider step count and
// result-valid flag. Uses dpps_pkg for the command and status structs.
`include "assert_macros.svh"

module dpps_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  dpps_pkg::dp_status_type status,
   output dpps_pkg::dp_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PREP   = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   localparam int CB = dpps_pkg::CNT_BITS;

   logic [2:0]    state_ff, state_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      cmd.load_req = accept;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_init = 1'b1;
            cnt_in       = CB'(dpps_pkg::QUOT_BITS - 1);
            if (status.is_measure && !status.off_ge_span) begin
               state_in = S_DIV;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_NEXT(a_div_exit, clock, reset, (state_ff == S_DIV) && (cnt_ff == '0), state_ff == S_FINISH)
   `ASSERT_NEXT(a_load_sets_valid, clock, reset, cmd.load_rsp, rsp_valid_ff && (state_ff == S_IDLE))

endmodule
